@@ hdl/tccw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, widths and types for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	// screen geometry
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int IDX_W   = $clog2(ROWS * COLUMNS);
	localparam int PHASE_W = $clog2(TAB_STOP);
	localparam int CNT_W   = $clog2(TAB_STOP + 1);

	// port widths
	localparam int CODE_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int KIND_W     = 2;
	localparam int OUT_IDX_W  = 11;
	localparam int OUT_ROW_W  = 5;
	localparam int OUT_COL_W  = 7;

	localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(7);

	// character codes
	localparam logic [CODE_W-1:0] CODE_NUL = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_TAB = CODE_W'(9);
	localparam logic [CODE_W-1:0] CODE_LF  = CODE_W'(10);
	localparam logic [CODE_W-1:0] CODE_CR  = CODE_W'(13);

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CELL   = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_SCROLL = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_CURSOR = KIND_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SCROLL,
		ST_CURSOR
	} state_t;

	typedef struct packed {
		logic              load;
		logic              cell_adv;
		logic [KIND_W-1:0] kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ld_has_cells;
		logic ld_scroll;
		logic cell_last;
		logic scroll;
	} dp_status_t;

endpackage

`default_nettype wire

@@ hdl/tccw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: accepts a character, then steps through cell writes, an optional
// scroll request and the final cursor result.
// ----------------------------------------------------------------------------
module tccw_ctrl
	import tccw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            last,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.ld_has_cells) begin
						state_nxt = ST_CELL;
					end else if (status.ld_scroll) begin
						state_nxt = ST_SCROLL;
					end else begin
						state_nxt = ST_CURSOR;
					end
				end
			end
			ST_CELL: begin
				if (out_ready && status.cell_last) begin
					state_nxt = status.scroll ? ST_SCROLL : ST_CURSOR;
				end
			end
			ST_SCROLL: begin
				if (out_ready) begin
					state_nxt = ST_CURSOR;
				end
			end
			ST_CURSOR: begin
				if (out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		last         = 1'b0;
		cmd.load     = 1'b0;
		cmd.cell_adv = 1'b0;
		cmd.kind     = KIND_CURSOR;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CELL: begin
				out_valid    = 1'b1;
				cmd.kind     = KIND_CELL;
				cmd.cell_adv = out_ready;
			end
			ST_SCROLL: begin
				out_valid = 1'b1;
				cmd.kind  = KIND_SCROLL;
			end
			ST_CURSOR: begin
				out_valid = 1'b1;
				last      = 1'b1;
				cmd.kind  = KIND_CURSOR;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/tccw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_datapath
// Cursor state, attribute register, and the per-transaction result fields:
// cell write index and count, scroll flag and final cursor index.
// ----------------------------------------------------------------------------
module tccw_datapath
	import tccw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CODE_W-1:0] char_code,
	input  wire logic              cfg_wr_en,
	input  wire logic [ATTR_W-1:0] cfg_wr_data,
	input  wire ctrl_cmd_t         cmd,
	output dp_status_t             status,
	output logic [OUT_IDX_W-1:0]   cell_index,
	output logic [CODE_W-1:0]      glyph,
	output logic [ATTR_W-1:0]      attribute,
	output logic [OUT_ROW_W-1:0]   cursor_row,
	output logic [OUT_COL_W-1:0]   cursor_col
);

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [PHASE_W-1:0] phase_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [CODE_W-1:0]  glyph_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   cur_idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               scroll_q;

	logic [ROW_W-1:0]   row_nxt;
	logic [COL_W-1:0]   col_nxt;
	logic [PHASE_W-1:0] phase_nxt;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [CODE_W-1:0]  glyph_nxt;
	logic               down;
	logic               scroll_nxt;
	logic [CNT_W-1:0]   span;
	logic [COL_W:0]     tab_end;
	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic [IDX_W-1:0]   base_idx;
	logic [IDX_W-1:0]   cur_idx_nxt;

	assign span     = CNT_W'(TAB_STOP) - CNT_W'(phase_q);
	assign tab_end  = (COL_W+1)'(col_q) + (COL_W+1)'(span);
	assign col_inc  = (COL_W+1)'(col_q) + (COL_W+1)'(1);
	assign row_inc  = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
	assign base_idx = IDX_W'(row_q) * IDX_W'(COLUMNS) + IDX_W'(col_q);

	// next cursor position and number of cell writes for the incoming code
	always_comb begin
		col_nxt   = col_q;
		phase_nxt = phase_q;
		cnt_nxt   = '0;
		glyph_nxt = char_code;
		down      = 1'b0;
		if (char_code == CODE_LF) begin
			down = 1'b1;
		end else if (char_code == CODE_CR) begin
			col_nxt   = '0;
			phase_nxt = '0;
		end else if (char_code == CODE_TAB) begin
			glyph_nxt = '0;
			phase_nxt = '0;
			if (tab_end >= (COL_W+1)'(COLUMNS)) begin
				// blanks stop at the last column, cursor wraps
				cnt_nxt = CNT_W'((COL_W+1)'(COLUMNS) - (COL_W+1)'(col_q));
				col_nxt = '0;
				down    = 1'b1;
			end else begin
				cnt_nxt = span;
				col_nxt = COL_W'(tab_end);
			end
		end else if (char_code != CODE_NUL) begin
			cnt_nxt = CNT_W'(1);
			if (col_inc >= (COL_W+1)'(COLUMNS)) begin
				col_nxt   = '0;
				phase_nxt = '0;
				down      = 1'b1;
			end else begin
				col_nxt = COL_W'(col_inc);
				if (phase_q == PHASE_W'(TAB_STOP - 1)) begin
					phase_nxt = '0;
				end else begin
					phase_nxt = phase_q + PHASE_W'(1);
				end
			end
		end
	end

	always_comb begin
		row_nxt    = row_q;
		scroll_nxt = 1'b0;
		if (down) begin
			if (row_inc >= (ROW_W+1)'(ROWS)) begin
				row_nxt    = ROW_W'(ROWS - 1);
				scroll_nxt = 1'b1;
			end else begin
				row_nxt = ROW_W'(row_inc);
			end
		end
	end

	assign cur_idx_nxt = IDX_W'(row_nxt) * IDX_W'(COLUMNS) + IDX_W'(col_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			phase_q  <= '0;
			attr_q   <= ATTR_RESET;
			cnt_q    <= '0;
			scroll_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				row_q    <= row_nxt;
				col_q    <= col_nxt;
				phase_q  <= phase_nxt;
				cnt_q    <= cnt_nxt;
				scroll_q <= scroll_nxt;
			end else if (cmd.cell_adv) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q   <= glyph_nxt;
			idx_q     <= base_idx;
			cur_idx_q <= cur_idx_nxt;
		end else if (cmd.cell_adv) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign status.ld_has_cells = (cnt_nxt != '0);
	assign status.ld_scroll    = scroll_nxt;
	assign status.cell_last    = (cnt_q == CNT_W'(1));
	assign status.scroll       = scroll_q;

	always_comb begin
		cell_index = '0;
		glyph      = '0;
		attribute  = '0;
		case (cmd.kind)
			KIND_CELL: begin
				cell_index = OUT_IDX_W'(idx_q);
				glyph      = glyph_q;
				attribute  = attr_q;
			end
			KIND_CURSOR: begin
				cell_index = OUT_IDX_W'(cur_idx_q);
			end
			default: begin
				cell_index = '0;
			end
		endcase
	end

	assign cursor_row = OUT_ROW_W'(row_q);
	assign cursor_col = OUT_COL_W'(col_q);

endmodule

`default_nettype wire

@@ hdl/text_console_char_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-to-screen writer for an 80 x 25 text console with cursor tracking.
// ----------------------------------------------------------------------------
// One character is taken per transaction and turned into a short burst of
// results on the output channel, one result per cycle whenever out_ready is
// high. The burst holds cell writes (one for a printable code, up to eight
// blanks for a tab), then a scroll request if the cursor moved below the last
// row, then a cursor-position result marked last. Every result of a
// transaction already carries the final cursor row and column. A character
// is accepted in the idle state before its results go out, and the next
// character is taken only after the cursor result has left.
// The attribute register resets to 7 and is written through cfg_wr_en.
// ----------------------------------------------------------------------------
module text_console_char_writer
	import tccw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [ATTR_W-1:0]    cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CODE_W-1:0]    char_code,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [KIND_W-1:0]         kind,
	output logic [OUT_IDX_W-1:0]      cell_index,
	output logic [CODE_W-1:0]         glyph,
	output logic [ATTR_W-1:0]         attribute,
	output logic [OUT_ROW_W-1:0]      cursor_row,
	output logic [OUT_COL_W-1:0]      cursor_col,
	output logic                      last
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last),
		.status    (status),
		.cmd       (cmd)
	);

	tccw_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.cell_index  (cell_index),
		.glyph       (glyph),
		.attribute   (attribute),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col)
	);

	assign kind = cmd.kind;

endmodule

`default_nettype wire

@@ dv/tccw_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_result_check
// Watches both channels and the attribute register port of the console writer,
// tracks the cursor on its own and compares every result with the expected one.
// ----------------------------------------------------------------------------
module tccw_result_check
	import tccw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [ATTR_W-1:0]    cfg_wr_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic [CODE_W-1:0]    char_code,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [KIND_W-1:0]    kind,
	input  wire logic [OUT_IDX_W-1:0] cell_index,
	input  wire logic [CODE_W-1:0]    glyph,
	input  wire logic [ATTR_W-1:0]    attribute,
	input  wire logic [OUT_ROW_W-1:0] cursor_row,
	input  wire logic [OUT_COL_W-1:0] cursor_col,
	input  wire logic                 last,
	output int                        mismatch_count,
	output int                        results_owed
);

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [OUT_IDX_W-1:0] cell_index;
		logic [CODE_W-1:0]    glyph;
		logic [ATTR_W-1:0]    attribute;
		logic [OUT_ROW_W-1:0] cursor_row;
		logic [OUT_COL_W-1:0] cursor_col;
		logic                 last;
	} screen_result_t;

	screen_result_t    owed_results[$];
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] cell_attr;

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// moves the cursor for one character and queues the results it causes
	task automatic predict_char(input logic [CODE_W-1:0] code);
		screen_result_t burst[$];
		screen_result_t r;
		int             span;
		logic           move_down;
		move_down = 1'b0;
		if (code == CODE_LF) begin
			move_down = 1'b1;
		end else if (code == CODE_CR) begin
			cur_col = 0;
		end else if (code == CODE_TAB) begin
			span = TAB_STOP - (cur_col % TAB_STOP);
			for (int i = 0; i < span; i++) begin
				if (cur_col + i < COLUMNS) begin
					r = '0;
					r.kind = KIND_CELL;
					r.cell_index = OUT_IDX_W'(cur_row * COLUMNS + cur_col + i);
					r.attribute = cell_attr;
					burst.push_back(r);
				end
			end
			cur_col += span;
			if (cur_col >= COLUMNS) begin
				cur_col = 0;
				move_down = 1'b1;
			end
		end else if (code != CODE_NUL) begin
			r = '0;
			r.kind = KIND_CELL;
			r.cell_index = OUT_IDX_W'(cur_row * COLUMNS + cur_col);
			r.glyph = code;
			r.attribute = cell_attr;
			burst.push_back(r);
			cur_col++;
			if (cur_col >= COLUMNS) begin
				cur_col = 0;
				move_down = 1'b1;
			end
		end

		if (move_down) begin
			if (cur_row + 1 >= ROWS) begin
				cur_row = ROWS - 1;
				r = '0;
				r.kind = KIND_SCROLL;
				burst.push_back(r);
			end else begin
				cur_row++;
			end
		end

		r = '0;
		r.kind = KIND_CURSOR;
		r.cell_index = OUT_IDX_W'(cur_row * COLUMNS + cur_col);
		r.last = 1'b1;
		burst.push_back(r);

		// every result carries the cursor as it stands after the character
		foreach (burst[i]) begin
			r = burst[i];
			r.cursor_row = OUT_ROW_W'(cur_row);
			r.cursor_col = OUT_COL_W'(cur_col);
			owed_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		screen_result_t want;
		if (!arst_n) begin
			cur_row = 0;
			cur_col = 0;
			cell_attr = ATTR_RESET;
			owed_results.delete();
			mismatch_count = 0;
			results_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result: kind %0d, cell_index %0d", kind, cell_index);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("cell_index", want.cell_index, cell_index);
					check_field("glyph", want.glyph, glyph);
					check_field("attribute", want.attribute, attribute);
					check_field("cursor_row", want.cursor_row, cursor_row);
					check_field("cursor_col", want.cursor_col, cursor_col);
					check_field("last", want.last, last);
				end
			end
			if (in_valid && in_ready)
				predict_char(char_code);
			// a new attribute applies from the next transaction on
			if (cfg_wr_en)
				cell_attr = cfg_wr_data;
			results_owed <= owed_results.size();
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives characters and attribute settings into the console writer with random
// gaps and output stalls; a separate result checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import tccw_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [ATTR_W-1:0]    cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic [CODE_W-1:0]    char_code = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [KIND_W-1:0]    kind;
	logic [OUT_IDX_W-1:0] cell_index;
	logic [CODE_W-1:0]    glyph;
	logic [ATTR_W-1:0]    attribute;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [OUT_COL_W-1:0] cursor_col;
	logic                 last;

	bit idle_on = 1'b1;
	int stall_left = 0;
	int mismatch_count;
	int results_owed;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	text_console_char_writer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.cell_index  (cell_index),
		.glyph       (glyph),
		.attribute   (attribute),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.last        (last)
	);

	tccw_result_check u_result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.cell_index     (cell_index),
		.glyph          (glyph),
		.attribute      (attribute),
		.cursor_row     (cursor_row),
		.cursor_col     (cursor_col),
		.last           (last),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// random output back-pressure bursts, started only while idle_on is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [CODE_W-1:0] printable_code();
		logic [CODE_W-1:0] c;
		do
			c = CODE_W'($urandom_range(1, 255));
		while (c == CODE_TAB || c == CODE_LF || c == CODE_CR);
		return c;
	endfunction

	// valid stays up between back-to-back transactions
	task automatic send_char(input logic [CODE_W-1:0] code);
		int gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= code;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly text lines with tabs and line endings, plus line-feed runs and noise
	task automatic run_phase(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
						: $urandom_range(0, 12);
					for (int k = 0; k < len; k++)
						send_char(($urandom_range(0, 4) == 0) ? CODE_TAB : printable_code());
					sent += len;
					case ($urandom_range(0, 3))
						0: begin
							send_char(CODE_CR);
							send_char(CODE_LF);
							sent += 2;
						end
						1: begin
							send_char(CODE_LF);
							sent++;
						end
						2: begin
							send_char(CODE_CR);
							sent++;
						end
						default: ;
					endcase
				end
				6, 7: begin
					len = $urandom_range(1, 8);
					repeat (len) send_char(CODE_LF);
					sent += len;
				end
				default: begin
					len = $urandom_range(1, 6);
					repeat (len) send_char(CODE_W'($urandom_range(0, 255)));
					sent += len;
				end
			endcase
		end
	endtask

	initial begin
		logic [CODE_W-1:0] opening[$];
		opening = '{CODE_NUL, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
			CODE_TAB, CODE_TAB, CODE_CR, CODE_LF, CODE_NUL};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			send_char(opening[i]);
		// from column 0 the tenth tab reaches the row end and wraps
		repeat (10) send_char(CODE_TAB);

		set_attribute(8'hFF);
		run_phase(110);
		set_attribute(8'h00);
		run_phase(110);
		set_attribute(ATTR_W'($urandom_range(0, 255)));
		run_phase(110);
		set_attribute(8'h5A);
		idle_on <= 1'b0;
		run_phase(110);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
